[rtl/od_pkg.sv]
`timescale 1ns / 1ps
package od_pkg;
    localparam int MAX_NODES_DEF   = 64;
    localparam int MAX_CHOICES_DEF = 16;
    localparam logic [23:0] MASK24 = 24'hFFFFFF;
    localparam logic [23:0] MIN_GEN = 24'd768;
    localparam int FEET_PER_MILE = 5280;

    // 5280 = 165 * 32, the odd factor is divided by a reciprocal multiply
    localparam int MILE_LOW_BITS = 5;
    localparam int MILE_SHIFT    = 36;
    localparam int MILE_ODD      = FEET_PER_MILE >> MILE_LOW_BITS;
    localparam logic [28:0] MILE_RECIP =
        29'(((64'd1 << MILE_SHIFT) + 64'(MILE_ODD - 1)) / 64'(MILE_ODD));

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_SCAN  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        REG_ZONE_BASE  = 1'b0,
        REG_NODE_COUNT = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_WRITE,
        S_QRD,
        S_QMUL,
        S_QOUT,
        S_SRD_A,
        S_SRD_B,
        S_SMUL,
        S_SCMP,
        S_PAD,
        S_OUT
    } t_state;
endpackage

[rtl/od_skim_store_and_prism_scan.sv]
`timescale 1ns / 1ps
// Origin-destination skim store. A write converts feet to miles by a
// reciprocal multiply, then does the store write; a pair query reads one
// slot, and a prism scan walks up to node_count nodes and then emits any
// padded words; the two stores each have a single read port, so each node
// takes two reads and the scan walks the nodes one at a time. Results leave
// through one output register; while a result word waits there the block
// waits with it, and a new word is taken once the last result word of the
// previous one is in the output register.
module od_skim_store_and_prism_scan
    import od_pkg::*;
#(
    parameter int MAX_NODES   = od_pkg::MAX_NODES_DEF,
    parameter int MAX_CHOICES = od_pkg::MAX_CHOICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_origin,
    input  logic [15:0] i_destination,
    input  logic [23:0] i_time_value,
    input  logic [23:0] i_distance_feet,
    input  logic [15:0] i_value_of_distance,
    input  logic [4:0]  i_max_choices,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_location,
    output logic [23:0] o_trip_time,
    output logic [23:0] o_distance_miles,
    output logic [23:0] o_generalized_time,
    output logic        o_out_of_range,
    output logic        o_last
);
    localparam int IW = $clog2(MAX_NODES);
    localparam int AW = 2 * IW;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int KW = $clog2(MAX_CHOICES + 1);

    logic [15:0] r_zone_base;
    logic [6:0]  r_node_count;

    t_state r_state, n_state;

    logic [IW-1:0] r_oi, r_di, r_j;
    logic [CW-1:0] r_cnt;
    logic        r_ok, r_oor;
    logic [23:0] r_tv;
    logic [15:0] r_vod;
    logic [KW-1:0] r_k, r_got;
    logic [27:0] r_num;
    logic [23:0] r_t, r_d, r_t1, r_g;
    logic [40:0] r_prod;
    logic [33:0] r_leg1;
    logic [23:0] r_quo;

    logic [15:0] r_o_loc;
    logic [23:0] r_o_tt, r_o_dm, r_o_gt;
    logic        r_o_oor, r_o_last, r_o_valid;

    logic [CW-1:0] active_n;
    logic [16:0] od, dd;
    logic o_in, d_in, zero_in;
    logic [KW-1:0] want_k;

    always_comb begin
        if (32'(r_node_count) >= 32'(MAX_NODES)) begin
            active_n = CW'(MAX_NODES);
        end else begin
            active_n = CW'(r_node_count);
        end
        od = {1'b0, i_origin} - {1'b0, r_zone_base};
        dd = {1'b0, i_destination} - {1'b0, r_zone_base};
        o_in = !od[16] && (32'(od[15:0]) < 32'(active_n));
        d_in = !dd[16] && (32'(dd[15:0]) < 32'(active_n));
        zero_in = (i_origin == 16'd0) || (i_destination == 16'd0);
        if (32'(i_max_choices) > 32'(MAX_CHOICES)) begin
            want_k = KW'(MAX_CHOICES);
        end else if (i_max_choices == 5'd0) begin
            want_k = KW'(1);
        end else begin
            want_k = KW'(i_max_choices);
        end
    end

    logic          mem_we;
    logic [AW-1:0] waddr, raddr;
    logic [23:0]   t_rd, d_rd;

    od_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_time (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(waddr), .i_wdata(r_tv),
        .i_raddr(raddr), .o_rdata(t_rd)
    );
    od_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_dist (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(waddr), .i_wdata(r_quo),
        .i_raddr(raddr), .o_rdata(d_rd)
    );

    assign waddr  = {r_oi, r_di};
    assign mem_we = (r_state == S_WRITE);

    always_comb begin
        unique case (r_state)
            S_SRD_A: raddr = {r_oi, r_j};
            S_SRD_B: raddr = {r_j, r_di};
            default: raddr = {r_oi, r_di};
        endcase
    end

    logic accept, out_free;
    assign out_free = !r_o_valid || !i_stall;
    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);

    logic [32:0] feet_q8;
    logic [56:0] miles_prod;
    logic [32:0] wdist;
    logic [34:0] cost;
    logic [33:0] gq;
    assign feet_q8    = {1'b0, i_distance_feet, 8'd0} + 33'(FEET_PER_MILE / 2);
    assign miles_prod = r_num * MILE_RECIP;
    assign wdist      = 33'((r_prod + 41'd128) >> 8);
    assign cost       = 35'(r_leg1) + 35'(r_t1) + 35'(wdist);
    assign gq         = 34'(r_t1) + 34'(wdist);

    logic scan_pass;
    logic scan_take, pad_take, out_take;
    logic [KW-1:0] got_next;
    logic last_hit;
    assign scan_pass = (cost <= 35'(r_tv));
    assign got_next  = r_got + KW'(1);
    assign last_hit  = (got_next == r_k);
    assign scan_take = (r_state == S_SCMP) && scan_pass && out_free;
    assign pad_take  = (r_state == S_PAD) && (r_got != r_k) && out_free;
    assign out_take  = (r_state == S_OUT) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_WRITE: n_state = S_DIV;
                        CMD_QUERY: n_state = (!zero_in && o_in && d_in) ? S_QRD : S_OUT;
                        CMD_SCAN:  n_state = (!zero_in && o_in && d_in) ? S_SRD_A : S_PAD;
                        default:   n_state = S_OUT;
                    endcase
                end
            end
            S_DIV:   n_state = r_ok ? S_WRITE : S_OUT;
            S_WRITE: n_state = S_OUT;
            S_QRD:   n_state = S_QMUL;
            S_QMUL:  n_state = S_QOUT;
            S_QOUT:  n_state = S_OUT;
            S_SRD_A: n_state = S_SRD_B;
            S_SRD_B: n_state = S_SMUL;
            S_SMUL:  n_state = S_SCMP;
            S_SCMP: begin
                if (!scan_pass || out_free) begin
                    if (scan_pass && last_hit) begin
                        n_state = S_IDLE;
                    end else if (32'(r_j) + 1 >= 32'(r_cnt)) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_SRD_A;
                    end
                end
            end
            S_PAD: begin
                if ((r_got == r_k) || (out_free && last_hit)) begin
                    n_state = S_IDLE;
                end
            end
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_zone_base  <= 16'd1;
            r_node_count <= 7'd64;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_index))
                    REG_ZONE_BASE:  r_zone_base  <= i_cfg_data;
                    REG_NODE_COUNT: r_node_count <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            r_o_valid <= out_take || scan_take || pad_take || (r_o_valid && i_stall);
            r_state   <= n_state;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_oi  <= IW'(od[15:0]);
                        r_di  <= IW'(dd[15:0]);
                        r_ok  <= !zero_in && o_in && d_in;
                        r_oor <= (t_cmd'(i_cmd) != CMD_NONE) && !zero_in && !(o_in && d_in);
                        r_tv  <= i_time_value;
                        r_vod <= i_value_of_distance;
                        r_k   <= want_k;
                        r_got <= '0;
                        r_j   <= '0;
                        r_cnt <= active_n;
                        r_num <= feet_q8[32:MILE_LOW_BITS];
                        r_quo <= '0;
                        r_t   <= '0;
                        r_d   <= '0;
                        r_g   <= '0;
                    end
                end
                S_DIV: begin
                    r_quo <= 24'(miles_prod[56:MILE_SHIFT]);
                end
                S_QMUL: begin
                    r_t1   <= t_rd;
                    r_t    <= t_rd;
                    r_d    <= d_rd;
                    r_prod <= 41'(d_rd) * 41'(r_vod);
                end
                S_QOUT: begin
                    if (gq < 34'(MIN_GEN)) begin
                        r_g <= MIN_GEN;
                    end else if (gq > 34'(MASK24)) begin
                        r_g <= MASK24;
                    end else begin
                        r_g <= gq[23:0];
                    end
                end
                S_SRD_B: begin
                    r_t1   <= t_rd;
                    r_prod <= 41'(d_rd) * 41'(r_vod);
                end
                S_SMUL: begin
                    r_leg1 <= gq;
                    r_t1   <= t_rd;
                    r_prod <= 41'(d_rd) * 41'(r_vod);
                end
                S_SCMP: begin
                    if (n_state == S_SRD_A) begin
                        r_j <= r_j + IW'(1);
                    end
                end
                default: ;
            endcase

            if (out_take) begin
                r_o_loc  <= '0;
                r_o_tt   <= r_t;
                r_o_dm   <= r_d;
                r_o_gt   <= r_g;
                r_o_oor  <= r_oor;
                r_o_last <= 1'b1;
            end else if (scan_take) begin
                r_o_loc  <= 16'(r_j) + 16'd1;
                r_o_tt   <= '0;
                r_o_dm   <= '0;
                r_o_gt   <= '0;
                r_o_oor  <= 1'b0;
                r_o_last <= last_hit;
            end else if (pad_take) begin
                r_o_loc  <= '0;
                r_o_tt   <= '0;
                r_o_dm   <= '0;
                r_o_gt   <= '0;
                r_o_oor  <= r_oor;
                r_o_last <= last_hit;
            end
            if (scan_take || pad_take) begin
                r_got <= got_next;
            end
        end
    end

    assign o_valid            = r_o_valid;
    assign o_location         = r_o_loc;
    assign o_trip_time        = r_o_tt;
    assign o_distance_miles   = r_o_dm;
    assign o_generalized_time = r_o_gt;
    assign o_out_of_range     = r_o_oor;
    assign o_last             = r_o_last;
endmodule

[rtl/od_ram.sv]
`timescale 1ns / 1ps
module od_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[verif/od_skim_store_and_prism_scan_checker.sv]
`timescale 1ns / 1ps
module od_skim_store_and_prism_scan_checker
    import od_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_origin,
    input  logic [15:0] i_destination,
    input  logic [23:0] i_time_value,
    input  logic [23:0] i_distance_feet,
    input  logic [15:0] i_value_of_distance,
    input  logic [4:0]  i_max_choices,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_location,
    input  logic [23:0] i_trip_time,
    input  logic [23:0] i_distance_miles,
    input  logic [23:0] i_generalized_time,
    input  logic        i_out_of_range,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int NODES   = MAX_NODES_DEF;
    localparam int CHOICES = MAX_CHOICES_DEF;

    typedef struct packed {
        logic [15:0] location;
        logic [23:0] trip_time;
        logic [23:0] distance_miles;
        logic [23:0] generalized_time;
        logic        out_of_range;
        logic        last;
    } t_skim_word;

    logic [23:0] time_mem [NODES*NODES];
    logic [23:0] dist_mem [NODES*NODES];
    logic [15:0] base_reg;
    logic [6:0]  count_reg;
    t_skim_word  skim_expected [$];
    int          fails = 0;

    initial begin
        foreach (time_mem[k]) begin
            time_mem[k] = '0;
            dist_mem[k] = '0;
        end
    end

    function automatic int active_count();
        return (count_reg < NODES) ? int'(count_reg) : NODES;
    endfunction

    function automatic bit zone_slot(input logic [15:0] zone, output int ix);
        ix = 0;
        if (zone < base_reg) return 0;
        ix = int'(zone - base_reg);
        return ix < active_count();
    endfunction

    function automatic logic [63:0] leg_cost(input int slot, input logic [15:0] vod);
        logic [63:0] w;
        w = ({40'd0, dist_mem[slot]} * {48'd0, vod} + 64'd128) >> 8;
        return {40'd0, time_mem[slot]} + w;
    endfunction

    task automatic push_word(input logic [15:0] loc, input logic [23:0] tt, input logic [23:0] dm,
                             input logic [23:0] gt, input logic oor, input logic lst);
        t_skim_word w;
        w.location = loc;
        w.trip_time = tt;
        w.distance_miles = dm;
        w.generalized_time = gt;
        w.out_of_range = oor;
        w.last = lst;
        skim_expected.push_back(w);
    endtask

    task automatic predict_word();
        int oi, di, slot, n, want, got, j;
        bit zero, ok;
        logic oor;
        logic [63:0] g, miles;
        logic [15:0] found [CHOICES];
        zero = (i_origin == 0) || (i_destination == 0);
        ok = !zero && zone_slot(i_origin, oi) && zone_slot(i_destination, di);
        oor = !zero && !ok;
        slot = oi * NODES + di;
        case (t_cmd'(i_cmd))
            CMD_WRITE: begin
                if (ok) begin
                    miles = ({40'd0, i_distance_feet} * 64'd256 + FEET_PER_MILE / 2)
                            / FEET_PER_MILE;
                    time_mem[slot] = i_time_value;
                    dist_mem[slot] = miles[23:0];
                end
                push_word(0, 0, 0, 0, oor, 1'b1);
            end
            CMD_QUERY: begin
                if (ok) begin
                    g = leg_cost(slot, i_value_of_distance);
                    if (g < MIN_GEN) g = MIN_GEN;
                    if (g > MASK24) g = MASK24;
                    push_word(0, time_mem[slot], dist_mem[slot], g[23:0], 1'b0, 1'b1);
                end else begin
                    push_word(0, 0, 0, 0, oor, 1'b1);
                end
            end
            CMD_SCAN: begin
                want = int'(i_max_choices);
                if (want > CHOICES) want = CHOICES;
                if (want == 0) want = 1;
                n = active_count();
                got = 0;
                if (ok) begin
                    for (j = 0; j < n && got < want; j++) begin
                        g = leg_cost(oi * NODES + j, i_value_of_distance)
                            + leg_cost(j * NODES + di, i_value_of_distance);
                        if (g <= {40'd0, i_time_value}) begin
                            found[got] = 16'(j + 1);
                            got++;
                        end
                    end
                end
                for (j = 0; j < want; j++)
                    push_word((j < got) ? found[j] : 16'd0, 0, 0, 0, oor, j + 1 == want);
            end
            default: push_word(0, 0, 0, 0, 1'b0, 1'b1);
        endcase
    endtask

    always @(posedge i_clk) begin
        t_skim_word got_w, exp_w;
        if (!i_rst_n) begin
            skim_expected.delete();
            base_reg <= 16'd1;
            count_reg <= 7'd64;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ZONE_BASE) base_reg <= i_cfg_data;
                else count_reg <= i_cfg_data[6:0];
            end
            if (i_in_valid && !i_in_stall) predict_word();
            if (i_out_valid && !i_out_stall) begin
                got_w = {i_location, i_trip_time, i_distance_miles, i_generalized_time,
                         i_out_of_range, i_last};
                if (skim_expected.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected word: %p", got_w);
                end else begin
                    exp_w = skim_expected.pop_front();
                    if (got_w !== exp_w) begin
                        fails++;
                        if (fails <= 10) $display("mismatch: expected %p got %p", exp_w, got_w);
                    end
                end
            end
        end
        o_pending <= skim_expected.size();
        o_fail_count <= fails;
    end
endmodule

[verif/od_skim_store_and_prism_scan_tb.sv]
`timescale 1ns / 1ps
module od_skim_store_and_prism_scan_tb;
    import od_pkg::*;

    localparam int NODES = MAX_NODES_DEF;
    localparam int LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = '0;
    logic [15:0] i_origin = '0;
    logic [15:0] i_destination = '0;
    logic [23:0] i_time_value = '0;
    logic [23:0] i_distance_feet = '0;
    logic [15:0] i_value_of_distance = '0;
    logic [4:0]  i_max_choices = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_location;
    logic [23:0] o_trip_time;
    logic [23:0] o_distance_miles;
    logic [23:0] o_generalized_time;
    logic        o_out_of_range;
    logic        o_last;

    int  fail_count;
    int  pending;
    int  cycles = 0;
    int  rx_gap = 0;
    bit  quiet = 0;
    bit  slot_written [NODES*NODES];
    int  base_now = 1;
    int  count_now = 64;

    od_skim_store_and_prism_scan u_dut (.*);

    od_skim_store_and_prism_scan_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_cmd, .i_origin, .i_destination, .i_time_value, .i_distance_feet,
        .i_value_of_distance, .i_max_choices,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_location(o_location), .i_trip_time(o_trip_time),
        .i_distance_miles(o_distance_miles), .i_generalized_time(o_generalized_time),
        .i_out_of_range(o_out_of_range), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("od_skim_store_and_prism_scan_tb NOT OK");
            $finish;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        int g;
        g = rx_gap;
        if (o_valid && !i_stall) g = quiet ? 0 : $urandom_range(0, 17);
        else if (g > 0) g--;
        rx_gap <= g;
        i_stall <= (g != 0);
    end

    function automatic int eff_count();
        return (count_now < NODES) ? count_now : NODES;
    endfunction

    function automatic bit zone_slot(input logic [15:0] zone, output int ix);
        ix = 0;
        if (int'(zone) < base_now) return 0;
        ix = int'(zone) - base_now;
        return ix < eff_count();
    endfunction

    function automatic logic [15:0] pick_zone();
        return 16'(base_now + $urandom_range(0, eff_count() - 1));
    endfunction

    task automatic put_word(input t_cmd c, input logic [15:0] o, input logic [15:0] d,
                            input logic [23:0] tv, input logic [23:0] ft,
                            input logic [15:0] vod, input logic [4:0] mc);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd <= c;
        i_origin <= o;
        i_destination <= d;
        i_time_value <= tv;
        i_distance_feet <= ft;
        i_value_of_distance <= vod;
        i_max_choices <= mc;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
    endtask

    task automatic fill(input int oi, input int di);
        if (!slot_written[oi*NODES+di]) begin
            put_word(CMD_WRITE, 16'(base_now + oi), 16'(base_now + di),
                     24'($urandom_range(0, 4000)), 24'($urandom_range(0, 20000)),
                     16'($urandom), 5'($urandom));
            slot_written[oi*NODES+di] = 1;
        end
    endtask

    task automatic issue(input t_cmd c, input logic [15:0] o, input logic [15:0] d,
                         input logic [23:0] tv, input logic [23:0] ft,
                         input logic [15:0] vod, input logic [4:0] mc);
        int oi, di, j;
        bit ok;
        ok = (o != 0) && (d != 0) && zone_slot(o, oi) && zone_slot(d, di);
        if (ok && c == CMD_QUERY) fill(oi, di);
        if (ok && c == CMD_SCAN) begin
            for (j = 0; j < eff_count(); j++) begin
                fill(oi, j);
                fill(j, di);
            end
        end
        put_word(c, o, d, tv, ft, vod, mc);
        if (ok && c == CMD_WRITE) slot_written[oi*NODES+di] = 1;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_cfg(input int base, input int cnt);
        drain();
        repeat (64) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_ZONE_BASE;
        i_cfg_data <= 16'(base);
        @(posedge i_clk);
        i_cfg_index <= REG_NODE_COUNT;
        i_cfg_data <= 16'(cnt);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        base_now = base;
        count_now = cnt;
    endtask

    task automatic random_word();
        int r;
        logic [15:0] o, d, vod;
        logic [23:0] tv, ft;
        r = $urandom_range(0, 99);
        vod = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h300));
        if (eff_count() == 0 || r >= 80) begin
            o = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
            d = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
            issue(t_cmd'($urandom_range(0, 3)), o, d, 24'($urandom), 24'($urandom), vod,
                  5'($urandom));
        end else begin
            o = pick_zone();
            d = pick_zone();
            if (r < 25) begin
                tv = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
                ft = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 20000));
                issue(CMD_WRITE, o, d, tv, ft, vod, 5'($urandom));
            end else if (r < 50) begin
                issue(CMD_QUERY, o, d, 24'($urandom), 24'($urandom), vod, 5'($urandom));
            end else begin
                // wide configs keep scans on the first row and column
                if (eff_count() > 8) begin
                    o = 16'(base_now);
                    d = 16'(base_now);
                end
                tv = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 16000));
                issue(CMD_SCAN, o, d, tv, 24'($urandom), vod, 5'($urandom_range(0, 31)));
            end
        end
    endtask

    initial begin
        int p, i;
        int bases [7] = '{1, 0, 65535, 300, 1000, 77, 5};
        int counts [7] = '{4, 8, 1, 0, 127, 6, 64};
        foreach (slot_written[k]) slot_written[k] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(CMD_WRITE, 16'd1, 16'd1, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 5'd0);
        issue(CMD_WRITE, 16'd64, 16'd64, 24'd0, 24'd0, 16'd0, 5'd31);
        issue(CMD_WRITE, 16'd1, 16'd64, 24'h123456, 24'd2640, 16'd1, 5'd1);
        issue(CMD_WRITE, 16'd2, 16'd3, 24'd5, 24'd1, 16'd0, 5'd16);
        issue(CMD_QUERY, 16'd1, 16'd1, 24'd0, 24'd0, 16'hFFFF, 5'd0);
        issue(CMD_QUERY, 16'd64, 16'd64, 24'd0, 24'd0, 16'd0, 5'd0);
        issue(CMD_QUERY, 16'd1, 16'd64, 24'd0, 24'd0, 16'h8000, 5'd0);
        issue(CMD_QUERY, 16'd2, 16'd3, 24'd0, 24'd0, 16'hFFFF, 5'd0);
        issue(CMD_WRITE, 16'd0, 16'd5, 24'd7, 24'd9, 16'd0, 5'd0);
        issue(CMD_WRITE, 16'd65, 16'd1, 24'd7, 24'd9, 16'd0, 5'd0);
        issue(CMD_QUERY, 16'd0, 16'd0, 24'd0, 24'd0, 16'd0, 5'd0);
        issue(CMD_QUERY, 16'd1, 16'd65, 24'd0, 24'd0, 16'd0, 5'd0);
        issue(CMD_QUERY, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 5'd31);
        issue(CMD_NONE, 16'd1, 16'd1, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 5'd31);
        issue(CMD_SCAN, 16'd0, 16'd3, 24'hFFFFFF, 24'd0, 16'd0, 5'd0);
        issue(CMD_SCAN, 16'd65, 16'd2, 24'hFFFFFF, 24'd0, 16'd0, 5'd31);
        issue(CMD_SCAN, 16'hFFFF, 16'd1, 24'd0, 24'd0, 16'd0, 5'd16);

        for (p = 0; p < 7; p++) begin
            set_cfg(bases[p], counts[p]);
            quiet = (p == 2);
            if (eff_count() > 0) begin
                issue(CMD_SCAN, 16'(base_now), 16'(base_now), 24'hFFFFFF, 24'd0, 16'hFFFF,
                      5'd17);
                issue(CMD_SCAN, 16'(base_now), (eff_count() > 8) ? 16'(base_now) : pick_zone(),
                      24'd0, 24'd0, 16'd0, 5'd16);
            end
            for (i = 0; i < ((counts[p] >= 64) ? 6 : 12); i++) begin
                if (p == 1 && i == 6) drain();
                random_word();
            end
        end
        quiet = 0;
        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) $display("od_skim_store_and_prism_scan_tb OK");
        else $display("od_skim_store_and_prism_scan_tb NOT OK");
        $finish;
    end
endmodule

[files.f]
rtl/od_pkg.sv
rtl/od_ram.sv
rtl/od_skim_store_and_prism_scan.sv
verif/od_skim_store_and_prism_scan_checker.sv
verif/od_skim_store_and_prism_scan_tb.sv
